// ----- rtl/core/psd_pkg.sv -----
// Shared types and constants for the point-to-segment distance pipeline.
package psd_pkg;

    localparam int DIST_WIDTH = 25;

    typedef enum logic [1:0] {
        CLS_START,
        CLS_END,
        CLS_MID
    } cls_t;

endpackage

// ----- rtl/core/psd_front.sv -----
// Front pipeline: differences, products, dot sums, region select and c1 squared.
module psd_front #(
    parameter int CW = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [CW-1:0]         point_x,
    input  logic [CW-1:0]         point_y,
    input  logic [CW-1:0]         seg_start_x,
    input  logic [CW-1:0]         seg_start_y,
    input  logic [CW-1:0]         seg_end_x,
    input  logic [CW-1:0]         seg_end_y,
    output logic                  out_valid,
    output psd_pkg::cls_t         out_cls,
    output logic [2*CW+1:0]       out_c2,
    output logic [2*CW+1:0]       out_ww,
    output logic [2*CW+1:0]       out_base,
    output logic [4*CW+3:0]       out_c1sq
);

    localparam int DW = CW + 1;
    localparam int Q  = 2 * CW + 2;
    localparam int H  = Q / 2;
    localparam int QW = 2 * Q;

    logic signed [DW-1:0] vx_reg, vy_reg, wx_reg, wy_reg, ux_reg, uy_reg;
    logic signed [Q-1:0]  vxvx_reg, vyvy_reg, vxwx_reg, vywy_reg;
    logic signed [Q-1:0]  wxwx_reg, wywy_reg, uxux_reg, uyuy_reg;
    logic [Q-1:0]         c2_reg, c1_reg, ww_reg, ee_reg;
    logic [Q-1:0]         c2b_reg, ww4_reg, base_reg;
    psd_pkg::cls_t        cls_reg, cls5_reg;
    psd_pkg::cls_t        cls_next;
    logic [2*H-1:0]       p00_reg;
    logic [Q-1:0]         p01_reg;
    logic [2*(Q-H)-1:0]   p11_reg;
    logic [Q-1:0]         c2c_reg, ww5_reg, base5_reg;
    logic [QW-1:0]        c1sq_reg;
    logic [4:0]           vld_reg;
    logic [H-1:0]         a0;
    logic [Q-H-1:0]       a1;

    always_comb
    begin
        if (c1_reg[Q-1] || c1_reg == '0)
        begin
            cls_next = psd_pkg::CLS_START;
        end
        else if (c1_reg >= c2_reg)
        begin
            cls_next = psd_pkg::CLS_END;
        end
        else
        begin
            cls_next = psd_pkg::CLS_MID;
        end
    end

    assign a0 = c1_reg[H-1:0];
    assign a1 = c1_reg[Q-1:H];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg <= {seg_end_x[CW-1], seg_end_x} - {seg_start_x[CW-1], seg_start_x};
            vy_reg <= {seg_end_y[CW-1], seg_end_y} - {seg_start_y[CW-1], seg_start_y};
            wx_reg <= {point_x[CW-1], point_x} - {seg_start_x[CW-1], seg_start_x};
            wy_reg <= {point_y[CW-1], point_y} - {seg_start_y[CW-1], seg_start_y};
            ux_reg <= {point_x[CW-1], point_x} - {seg_end_x[CW-1], seg_end_x};
            uy_reg <= {point_y[CW-1], point_y} - {seg_end_y[CW-1], seg_end_y};

            vxvx_reg <= vx_reg * vx_reg;
            vyvy_reg <= vy_reg * vy_reg;
            vxwx_reg <= vx_reg * wx_reg;
            vywy_reg <= vy_reg * wy_reg;
            wxwx_reg <= wx_reg * wx_reg;
            wywy_reg <= wy_reg * wy_reg;
            uxux_reg <= ux_reg * ux_reg;
            uyuy_reg <= uy_reg * uy_reg;

            c2_reg <= vxvx_reg + vyvy_reg;
            c1_reg <= vxwx_reg + vywy_reg;
            ww_reg <= wxwx_reg + wywy_reg;
            ee_reg <= uxux_reg + uyuy_reg;

            cls_reg  <= cls_next;
            c2b_reg  <= c2_reg;
            ww4_reg  <= ww_reg;
            base_reg <= (cls_next == psd_pkg::CLS_END) ? ee_reg : ww_reg;
            p00_reg  <= a0 * a0;
            p01_reg  <= a1 * a0;
            p11_reg  <= a1 * a1;

            cls5_reg  <= cls_reg;
            c2c_reg   <= c2b_reg;
            ww5_reg   <= ww4_reg;
            base5_reg <= base_reg;
            c1sq_reg  <= (QW'(p11_reg) << (2 * H)) + (QW'(p01_reg) << (H + 1))
                         + QW'(p00_reg);
        end
    end

    assign out_valid = vld_reg[4];
    assign out_cls   = cls5_reg;
    assign out_c2    = c2c_reg;
    assign out_ww    = ww5_reg;
    assign out_base  = base5_reg;
    assign out_c1sq  = c1sq_reg;

endmodule

// ----- rtl/core/psd_div.sv -----
// Restoring divider, one quotient bit per stage, then squared-distance select.
module psd_div #(
    parameter int Q = 50
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  psd_pkg::cls_t   in_cls,
    input  logic [Q-1:0]    in_c2,
    input  logic [Q-1:0]    in_ww,
    input  logic [Q-1:0]    in_base,
    input  logic [2*Q-1:0]  in_c1sq,
    output logic            out_valid,
    output logic [Q-1:0]    out_n
);

    logic [Q-1:0]  rem_w  [0:Q];
    logic [Q-1:0]  lo_w   [0:Q];
    logic [Q-1:0]  c2_w   [0:Q];
    logic [Q-1:0]  ww_w   [0:Q];
    logic [Q-1:0]  base_w [0:Q];
    psd_pkg::cls_t cls_w  [0:Q];
    logic          vld_w  [0:Q];
    logic [Q-1:0]  n_reg;
    logic          nvld_reg;
    logic          inexact;

    assign rem_w[0]  = in_c1sq[2*Q-1:Q];
    assign lo_w[0]   = in_c1sq[Q-1:0];
    assign c2_w[0]   = in_c2;
    assign ww_w[0]   = in_ww;
    assign base_w[0] = in_base;
    assign cls_w[0]  = in_cls;
    assign vld_w[0]  = in_valid;

    for (genvar i = 0; i < Q; i++)
    begin : g_stage
        logic [Q:0]    trial;
        logic [Q:0]    diff;
        logic          ge;
        logic [Q-1:0]  rem_reg, lo_reg, c2_reg, ww_reg, base_reg;
        psd_pkg::cls_t cls_reg;
        logic          vld_reg;

        assign trial = {rem_w[i], lo_w[i][Q-1]};
        assign diff  = trial - {1'b0, c2_w[i]};
        assign ge    = trial >= {1'b0, c2_w[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= ge ? diff[Q-1:0] : trial[Q-1:0];
                lo_reg   <= {lo_w[i][Q-2:0], ge};
                c2_reg   <= c2_w[i];
                ww_reg   <= ww_w[i];
                base_reg <= base_w[i];
                cls_reg  <= cls_w[i];
            end
        end

        assign rem_w[i+1]  = rem_reg;
        assign lo_w[i+1]   = lo_reg;
        assign c2_w[i+1]   = c2_reg;
        assign ww_w[i+1]   = ww_reg;
        assign base_w[i+1] = base_reg;
        assign cls_w[i+1]  = cls_reg;
        assign vld_w[i+1]  = vld_reg;
    end

    // floor(ww - c1^2/c2) = ww - ceil(c1^2/c2)
    assign inexact = rem_w[Q] != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvld_reg <= 1'b0;
        end
        else if (en)
        begin
            nvld_reg <= vld_w[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cls_w[Q] == psd_pkg::CLS_MID)
            begin
                n_reg <= ww_w[Q] - lo_w[Q] - Q'(inexact);
            end
            else
            begin
                n_reg <= base_w[Q];
            end
        end
    end

    assign out_valid = nvld_reg;
    assign out_n     = n_reg;

endmodule

// ----- rtl/core/psd_sqrt.sv -----
// Integer square root, one root bit per stage, with output saturation register.
module psd_sqrt #(
    parameter int Q = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [Q-1:0]                      in_n,
    output logic                              out_valid,
    output logic [psd_pkg::DIST_WIDTH-1:0]    distance
);

    localparam int R  = Q / 2;
    localparam int DW = psd_pkg::DIST_WIDTH;
    localparam int RW = (R > DW) ? R : DW;

    logic [Q-1:0]  x_w    [0:R];
    logic [R-1:0]  root_w [0:R];
    logic          vld_w  [0:R];
    logic [RW-1:0] root_ext;
    logic          sat;
    logic [DW-1:0] dist_reg;
    logic          dvld_reg;

    assign x_w[0]    = in_n;
    assign root_w[0] = '0;
    assign vld_w[0]  = in_valid;

    for (genvar i = 0; i < R; i++)
    begin : g_stage
        localparam int B = R - 1 - i;
        logic [Q:0]   t;
        logic [Q:0]   diff;
        logic         ge;
        logic [Q-1:0] x_reg;
        logic [R-1:0] root_reg;
        logic         vld_reg;

        assign t    = ((Q+1)'(root_w[i]) << (B + 1)) | ((Q+1)'(1) << (2 * B));
        assign diff = {1'b0, x_w[i]} - t;
        assign ge   = {1'b0, x_w[i]} >= t;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= ge ? diff[Q-1:0] : x_w[i];
                root_reg <= ge ? (root_w[i] | (R'(1) << B)) : root_w[i];
            end
        end

        assign x_w[i+1]    = x_reg;
        assign root_w[i+1] = root_reg;
        assign vld_w[i+1]  = vld_reg;
    end

    assign root_ext = RW'(root_w[R]);
    assign sat      = root_ext > RW'({DW{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= 1'b0;
        end
        else if (en)
        begin
            dvld_reg <= vld_w[R];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= sat ? {DW{1'b1}} : root_ext[DW-1:0];
        end
    end

    assign out_valid = dvld_reg;
    assign distance  = dist_reg;

endmodule

// ----- rtl/core/point_segment_distance_top.sv -----
// Throughput: one item per cycle; the whole pipeline advances unless the output
// register holds an item that is not taken.
// Stages: 5 front, 2*COORD_WIDTH+2 divider, 1 select, COORD_WIDTH+1 root, 1 output.
// Reset: asynchronous active-low rst_n clears all valid bits; data is not reset.
module point_segment_distance_top #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COORD_WIDTH-1:0]            point_x,
    input  logic [COORD_WIDTH-1:0]            point_y,
    input  logic [COORD_WIDTH-1:0]            seg_start_x,
    input  logic [COORD_WIDTH-1:0]            seg_start_y,
    input  logic [COORD_WIDTH-1:0]            seg_end_x,
    input  logic [COORD_WIDTH-1:0]            seg_end_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psd_pkg::DIST_WIDTH-1:0]    distance
);

    localparam int Q = 2 * COORD_WIDTH + 2;

    logic          en;
    logic          f_valid;
    psd_pkg::cls_t f_cls;
    logic [Q-1:0]  f_c2, f_ww, f_base;
    logic [2*Q-1:0] f_c1sq;
    logic          d_valid;
    logic [Q-1:0]  d_n;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    psd_front #(.CW(COORD_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .point_x     (point_x),
        .point_y     (point_y),
        .seg_start_x (seg_start_x),
        .seg_start_y (seg_start_y),
        .seg_end_x   (seg_end_x),
        .seg_end_y   (seg_end_y),
        .out_valid   (f_valid),
        .out_cls     (f_cls),
        .out_c2      (f_c2),
        .out_ww      (f_ww),
        .out_base    (f_base),
        .out_c1sq    (f_c1sq)
    );

    psd_div #(.Q(Q)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_cls    (f_cls),
        .in_c2     (f_c2),
        .in_ww     (f_ww),
        .in_base   (f_base),
        .in_c1sq   (f_c1sq),
        .out_valid (d_valid),
        .out_n     (d_n)
    );

    psd_sqrt #(.Q(Q)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_n      (d_n),
        .out_valid (out_valid),
        .distance  (distance)
    );

endmodule

// ----- rtl/core/psd_chk.sv -----
// Port-level checker for the distance pipeline, bound to the top level.
module psd_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [psd_pkg::DIST_WIDTH-1:0]    distance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(distance))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind point_segment_distance_top psd_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance)
);

// ----- test/tb_point_segment_distance_top.sv -----
// Self-checking testbench for the point-to-segment distance pipeline.
`timescale 1ns / 1ps

module tb_point_segment_distance_top;

    localparam int CW = 24;
    localparam int N_RANDOM = 1100;
    localparam int LATENCY = 3 * CW + 10;
    localparam logic [psd_pkg::DIST_WIDTH-1:0] DIST_MAX = '1;

    typedef struct {
        logic [CW-1:0] px, py, sx, sy, ex, ey;
        logic          has_exp;
        logic [psd_pkg::DIST_WIDTH-1:0] exp_dist;
    } seg_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [CW-1:0] point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y;
    logic out_valid;
    logic out_ready;
    logic [psd_pkg::DIST_WIDTH-1:0] distance;

    logic [psd_pkg::DIST_WIDTH-1:0] dist_q[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_start, n_end, n_mid;
    bit quiet;

    point_segment_distance_top #(.COORD_WIDTH(CW)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .out_valid(out_valid), .out_ready(out_ready), .distance(distance)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 47; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [psd_pkg::DIST_WIDTH-1:0] seg_distance(
        input logic [CW-1:0] px, py, sx, sy, ex, ey, output psd_pkg::cls_t cls);
        logic signed [63:0] vx, vy, wx, wy, dx, dy;
        logic signed [127:0] c1, c2, ww, num;
        logic [127:0] nsq;
        logic [63:0] d;
        vx = $signed(ex) - $signed(sx);
        vy = $signed(ey) - $signed(sy);
        wx = $signed(px) - $signed(sx);
        wy = $signed(py) - $signed(sy);
        dx = $signed(px) - $signed(ex);
        dy = $signed(py) - $signed(ey);
        c1 = 128'(vx) * 128'(wx) + 128'(vy) * 128'(wy);
        c2 = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
        ww = 128'(wx) * 128'(wx) + 128'(wy) * 128'(wy);
        if (c1 <= 0)
        begin
            cls = psd_pkg::CLS_START;
            nsq = ww;
        end
        else if (c1 >= c2)
        begin
            cls = psd_pkg::CLS_END;
            nsq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        end
        else
        begin
            cls = psd_pkg::CLS_MID;
            num = ww * c2 - c1 * c1;
            nsq = num / c2;
        end
        d = isqrt(nsq);
        if (d > 64'(DIST_MAX))
            d = 64'(DIST_MAX);
        return d[psd_pkg::DIST_WIDTH-1:0];
    endfunction

    task automatic send_item(input seg_row_t r);
        psd_pkg::cls_t cls;
        logic [psd_pkg::DIST_WIDTH-1:0] d;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        d = seg_distance(r.px, r.py, r.sx, r.sy, r.ex, r.ey, cls);
        if (r.has_exp && d != r.exp_dist)
        begin
            $display("%0t table row disagrees: expected %0d predicted %0d",
                $time, r.exp_dist, d);
            errors++;
        end
        case (cls)
            psd_pkg::CLS_START: n_start++;
            psd_pkg::CLS_END:   n_end++;
            default:            n_mid++;
        endcase
        in_valid    <= 1'b1;
        point_x     <= r.px;
        point_y     <= r.py;
        seg_start_x <= r.sx;
        seg_start_y <= r.sy;
        seg_end_x   <= r.ex;
        seg_end_y   <= r.ey;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        dist_q.push_back(r.has_exp ? r.exp_dist : d);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    function automatic seg_row_t rand_row();
        seg_row_t r;
        r.px = rand_coord();
        r.py = rand_coord();
        r.sx = rand_coord();
        r.sy = rand_coord();
        case ($urandom_range(0, 7))
            0: begin r.ex = r.sx; r.ey = r.sy; end
            1: begin r.ex = r.sx; r.ey = rand_coord(); end
            2: begin r.ex = rand_coord(); r.ey = r.sy; end
            3: begin r.ex = rand_coord(); r.ey = rand_coord(); r.px = r.ex; r.py = r.ey; end
            default: begin r.ex = rand_coord(); r.ey = rand_coord(); end
        endcase
        r.has_exp = 1'b0;
        r.exp_dist = '0;
        return r;
    endfunction

    localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE  = CW'(4096);
    localparam logic [CW-1:0] MONE = -CW'(4096);

    seg_row_t dir_table[] = '{
        '{'0, '0, '0, '0, '0, '0, 1'b1, '0},
        '{ONE, '0, '0, '0, '0, '0, 1'b1, psd_pkg::DIST_WIDTH'(4096)},
        '{'0, ONE, MONE, '0, ONE, '0, 1'b1, psd_pkg::DIST_WIDTH'(4096)},
        '{MONE, '0, '0, '0, ONE, '0, 1'b1, psd_pkg::DIST_WIDTH'(4096)},
        '{CW'(3*4096), '0, '0, '0, ONE, '0, 1'b1, psd_pkg::DIST_WIDTH'(2*4096)},
        '{ONE, '0, '0, '0, ONE, '0, 1'b1, '0},
        '{'0, '0, '0, '0, ONE, '0, 1'b1, '0},
        '{CW'(3*4096), CW'(4*4096), '0, '0, '0, '0, 1'b1, psd_pkg::DIST_WIDTH'(5*4096)},
        '{MAXP, MAXP, MINN, MINN, MINN, MINN, 1'b0, '0},
        '{MINN, MINN, MAXP, MAXP, MAXP, MAXP, 1'b0, '0},
        '{MAXP, MINN, MINN, MAXP, MAXP, MAXP, 1'b0, '0},
        '{MINN, MAXP, MINN, MINN, MAXP, MAXP, 1'b0, '0},
        '{MAXP, MINN, MINN, MINN, MAXP, MAXP, 1'b0, '0},
        '{'0, MAXP, MINN, '0, MAXP, '0, 1'b0, '0},
        '{'1, '1, '0, '0, '1, '0, 1'b0, '0},
        '{CW'(12345), CW'(-777), CW'(-5), CW'(9), CW'(40000), CW'(3), 1'b0, '0},
        '{CW'(1), CW'(1), '0, '0, CW'(2), CW'(1), 1'b0, '0},
        '{CW'(5), CW'(5), '0, '0, MAXP, MAXP, 1'b0, '0}
    };

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (dist_q.size() == 0)
            begin
                $display("%0t unexpected distance: expected none actual %0d",
                    $time, distance);
                errors++;
            end
            else
            begin
                if (distance !== dist_q[0])
                begin
                    $display("%0t distance: expected %0d actual %0d",
                        $time, dist_q[0], distance);
                    errors++;
                end
                void'(dist_q.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        seg_start_x = '0;
        seg_start_y = '0;
        seg_end_x = '0;
        seg_end_y = '0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_start = 0;
        n_end = 0;
        n_mid = 0;
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (dir_table[i])
            send_item(dir_table[i]);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 150)
                quiet = 1'b1;
            send_item(rand_row());
        end
        in_valid <= 1'b0;
        while (dist_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d items, checked %0d distances", n_sent, n_checked);
        $display("Cases: %0d start vertex, %0d end vertex, %0d interior",
            n_start, n_end, n_mid);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
